### hdl/mdpll_pkg.sv
// Package for the MFM digital PLL decoder: payload structs, window codes and
// the result bundle passed from the tracking loop to the output serialiser.
// No dependencies.
`default_nettype none

package mdpll_pkg;

   // Fixed field widths; the tracked delay is as wide as the flux interval.
   localparam int INTERVAL_BITS = 16;
   localparam int FLUX_BITS     = INTERVAL_BITS;
   localparam int INDEX_BITS    = 16;
   // A start-of-run leading bit plus up to four window bits.
   localparam int BUNDLE_BITS = 5;
   localparam int COUNT_BITS  = 3;

   typedef struct packed {
      logic [FLUX_BITS-1:0] flux_interval;
      logic                 start_of_run;
   } req_data_type;

   typedef struct packed {
      logic                  mfm_bit;
      logic [INDEX_BITS-1:0] flux_index;
      logic                  last_of_item;
   } rsp_data_type;

   // Window that an interval falls into.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_01,
      KIND_001,
      KIND_0001
   } kind_type;

   // All results of one input item, first bit in the least significant place.
   typedef struct packed {
      logic [BUNDLE_BITS-1:0] bits;
      logic [COUNT_BITS-1:0]  count;
      logic [INDEX_BITS-1:0]  index;
   } bundle_type;

endpackage

`default_nettype wire

### hdl/mfm_digital_pll_decoder.sv
// Top level of the MFM digital PLL decoder: input register, tracking loop and
// output serialiser. Depends on mdpll_pkg, mdpll_loop and mdpll_serializer.
`default_nettype none

// Each req transaction carries one flux-reversal interval. The interval is
// registered, then sorted against the tracked delay, and the delay is updated
// as the item moves on to the output stage; its MFM bits (up to five, including
// the leading 1 of a new run) are then handed out one per rsp transaction. An
// item holds the output stage until its last bit is taken, and an item with no
// bits does not hold it, so the sustained rate is one item per cycle for items
// of at most one bit while rsp_ready stays high; longer items are held back by
// the single-bit result port. The tracked delay is as wide as the flux interval
// and saturates at its all-ones value.

module mfm_digital_pll_decoder
   import mdpll_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_data_type      rsp_data
);

   req_data_type item_ff, item_in;
   logic         item_valid_ff, item_valid_in;
   logic         advance;
   logic         free;
   bundle_type   bundle;

   // The registered item moves on whenever the output stage can take its bundle.
   always_comb begin
      advance       = item_valid_ff && free;
      req_ready     = !item_valid_ff || free;
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   mdpll_loop u_loop (
      .clock   (clock),
      .reset   (reset),
      .item    (item_ff),
      .advance (advance),
      .bundle  (bundle)
   );

   mdpll_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/mdpll_loop.sv
// Tracking loop of the MFM digital PLL: window classification, delay update and
// run bookkeeping. Depends on mdpll_pkg.
`default_nettype none

module mdpll_loop
   import mdpll_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_data_type item,
   input  wire logic         advance,
   output bundle_type        bundle
);

   localparam int W = INTERVAL_BITS + 3;

   logic [INTERVAL_BITS-1:0] nominal_delay_ff, nominal_delay_in;
   logic                     run_started_ff, run_started_in;
   logic [INDEX_BITS-1:0]    interval_count_ff, interval_count_in;

   logic [INTERVAL_BITS-1:0] len;
   logic                     active;
   logic signed [W-1:0]      d, l, ll, quarter, eighth, x, half, target, hi, lo, max_val;
   kind_type                 kind;
   logic [3:0]               seq;
   logic [COUNT_BITS-1:0]    seq_len;

   // Operands: a new run seeds the delay with its own interval.
   always_comb begin
      len     = item.flux_interval;
      active  = item.start_of_run || run_started_ff;
      d       = item.start_of_run ? $signed({3'b000, len})
                                  : $signed({3'b000, nominal_delay_ff});
      l       = $signed({3'b000, len});
      ll      = l + l;
      quarter = d >>> 2;
      eighth  = d >>> 3;
      max_val = $signed({3'b000, {INTERVAL_BITS{1'b1}}});
   end

   // Window classification.
   always_comb begin
      if (l < quarter) begin
         kind = KIND_NONE;
      end else if (l < d + quarter) begin
         kind = KIND_01;
      end else if (l < d + d - quarter) begin
         kind = KIND_001;
      end else if (l < d + d + d) begin
         kind = KIND_0001;
      end else begin
         kind = KIND_NONE;
      end
   end

   // Target delay, halving with truncation toward zero, then clamp and saturate.
   always_comb begin
      case (kind)
         KIND_01:   x = d - l;
         KIND_001:  x = d - (ll >>> 2) - (ll >>> 3) + (ll >>> 5);
         KIND_0001: x = d - (l >>> 1);
         default:   x = '0;
      endcase
      half   = (x + $signed(W'(x < 0))) >>> 1;
      target = d - half;
      hi     = d + eighth;
      lo     = d - eighth;
      if (target > hi) begin
         target = hi;
      end else if (target < lo) begin
         target = lo;
      end
      if (target > max_val) begin
         target = max_val;
      end
   end

   // Result bits of the window, first bit in the least significant place.
   always_comb begin
      case (kind)
         KIND_01: begin
            seq     = 4'b0010;
            seq_len = 3'd2;
         end
         KIND_001: begin
            seq     = 4'b0100;
            seq_len = 3'd3;
         end
         KIND_0001: begin
            seq     = 4'b1000;
            seq_len = 3'd4;
         end
         default: begin
            seq     = 4'b0000;
            seq_len = 3'd0;
         end
      endcase
   end

   // Result bundle; an item before any run gives nothing.
   always_comb begin
      if (!active) begin
         bundle.bits  = '0;
         bundle.count = '0;
      end else if (item.start_of_run) begin
         bundle.bits  = {seq, 1'b1};
         bundle.count = seq_len + 3'd1;
      end else begin
         bundle.bits  = {1'b0, seq};
         bundle.count = seq_len;
      end
      bundle.index = item.start_of_run ? '0 : interval_count_ff;
   end

   // Next state.
   always_comb begin
      nominal_delay_in  = nominal_delay_ff;
      run_started_in    = run_started_ff;
      interval_count_in = interval_count_ff;
      if (advance && active) begin
         nominal_delay_in  = target[INTERVAL_BITS-1:0];
         run_started_in    = 1'b1;
         interval_count_in = item.start_of_run ? INDEX_BITS'(1) : interval_count_ff + 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_delay_ff  <= '0;
         run_started_ff    <= 1'b0;
         interval_count_ff <= '0;
      end else begin
         nominal_delay_ff  <= nominal_delay_in;
         run_started_ff    <= run_started_in;
         interval_count_ff <= interval_count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/mdpll_serializer.sv
// Output stage of the MFM digital PLL: holds one item's result bundle and hands
// it out one bit per rsp transaction. Depends on mdpll_pkg.
`default_nettype none

module mdpll_serializer
   import mdpll_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire bundle_type bundle,
   output logic            free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_data_type    rsp_data
);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [BUNDLE_BITS-1:0] bits_ff, bits_in;
   logic [INDEX_BITS-1:0]  index_ff, index_in;
   logic                   take;

   // The stage can take a new bundle once its last bit leaves.
   always_comb begin
      rsp_valid = (count_ff != '0);
      take      = rsp_valid && rsp_ready;
      free      = (count_ff == '0) || ((count_ff == COUNT_BITS'(1)) && rsp_ready);
   end

   // Next contents: a load overrides the shift.
   always_comb begin
      count_in = count_ff;
      bits_in  = bits_ff;
      index_in = index_ff;
      if (load) begin
         count_in = bundle.count;
         bits_in  = bundle.bits;
         index_in = bundle.index;
      end else if (take) begin
         count_in = count_ff - 1'b1;
         bits_in  = bits_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      index_ff <= index_in;
   end

   // Result payload.
   always_comb begin
      rsp_data.mfm_bit      = bits_ff[0];
      rsp_data.flux_index   = index_ff;
      rsp_data.last_of_item = (count_ff == COUNT_BITS'(1));
   end

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for mfm_digital_pll_decoder: drives flux intervals,
// predicts the decoded MFM bits and compares every rsp transaction in order.
// Depends on mdpll_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb
   import mdpll_pkg::*;
();

   localparam int LIMIT_CYCLES = 1000000;
   localparam int FLUX_MAX     = 65535;

   // Window that the random stimulus aims an interval at.
   typedef enum int {
      WIN_SHORT,
      WIN_01,
      WIN_001,
      WIN_0001,
      WIN_LONG,
      WIN_ANY
   } window_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;

   // Predicted loop state, following the decoder's tracked delay and run index.
   logic [15:0] track_delay = '0;
   logic        run_seeded  = 1'b0;
   logic [15:0] run_index   = '0;

   rsp_data_type expected_bits[$];
   rsp_data_type oldest_bit;

   int errors        = 0;
   int cycle_count   = 0;
   int intervals_fed = 0;
   int bits_checked  = 0;
   int sender_idle_pct = 0;
   int rsp_idle_pct    = 0;

   mfm_digital_pll_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Run limit, counted in clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate set by the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Works out the bits that one accepted interval produces and queues them.
   task automatic predict_bits(input req_data_type item);
      longint       d, l, target, hi, lo;
      kind_type     kind;
      int           n, j;
      rsp_data_type produced[5];
      n = 0;
      if (item.start_of_run) begin
         track_delay = item.flux_interval;
         run_index   = '0;
         run_seeded  = 1'b1;
         produced[n] = '{mfm_bit: 1'b1, flux_index: '0, last_of_item: 1'b0};
         n++;
      end else if (!run_seeded) begin
         return;
      end
      d      = track_delay;
      l      = item.flux_interval;
      target = d;
      kind   = KIND_NONE;
      if (l < d / 4) begin
         kind = KIND_NONE;
      end else if (l < d + d / 4) begin
         kind   = KIND_01;
         target = d - (d - l) / 2;
      end else if (l < d + d - d / 4) begin
         kind   = KIND_001;
         target = d - (d - (l + l) / 4 - (l + l) / 8 + (l + l) / 32) / 2;
      end else if (l < d + d + d) begin
         kind   = KIND_0001;
         target = d - (d - l / 2) / 2;
      end
      // A window of kind k gives k zeros followed by a one.
      if (kind != KIND_NONE) begin
         for (j = 0; j < int'(kind); j++) begin
            produced[n] = '{mfm_bit: 1'b0, flux_index: run_index, last_of_item: 1'b0};
            n++;
         end
         produced[n] = '{mfm_bit: 1'b1, flux_index: run_index, last_of_item: 1'b0};
         n++;
      end
      // The delay moves by at most an eighth of itself and saturates.
      hi = d + d / 8;
      lo = d - d / 8;
      if (target > hi) begin
         target = hi;
      end else if (target < lo) begin
         target = lo;
      end
      if (target < 0) begin
         target = 0;
      end
      if (target > FLUX_MAX) begin
         target = FLUX_MAX;
      end
      track_delay = 16'(target);
      run_index   = run_index + 16'd1;
      if (n > 0) begin
         produced[n-1].last_of_item = 1'b1;
      end
      for (j = 0; j < n; j++) begin
         expected_bits = {expected_bits, produced[j]};
      end
   endtask

   // Drives one req transaction after a random gap and returns at the edge
   // where it is accepted.
   task automatic send_interval(input logic [15:0] interval, input logic start);
      req_data_type item;
      item.flux_interval = interval;
      item.start_of_run  = start;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_bits(item);
      intervals_fed++;
   endtask

   // Holds the sender off until every outstanding bit has been received.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bits.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic flag_mismatch(input string field, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compares each rsp transaction with the oldest predicted bit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bits_checked++;
         if (expected_bits.size() == 0) begin
            errors++;
            $display("%0t: unexpected bit, expected none, actual bit %0b index %0d last %0b",
                     $time, rsp_data.mfm_bit, rsp_data.flux_index, rsp_data.last_of_item);
         end else begin
            oldest_bit = expected_bits.pop_front();
            if (rsp_data.mfm_bit !== oldest_bit.mfm_bit) begin
               flag_mismatch("mfm_bit", oldest_bit.mfm_bit, rsp_data.mfm_bit);
            end
            if (rsp_data.flux_index !== oldest_bit.flux_index) begin
               flag_mismatch("flux_index", oldest_bit.flux_index, rsp_data.flux_index);
            end
            if (rsp_data.last_of_item !== oldest_bit.last_of_item) begin
               flag_mismatch("last_of_item", oldest_bit.last_of_item, rsp_data.last_of_item);
            end
         end
      end
   end

   // Chooses an interval in the requested window of the current delay.
   function automatic logic [15:0] pick_interval(input window_type win);
      int d, lo, hi;
      d  = track_delay;
      lo = 0;
      hi = FLUX_MAX;
      case (win)
         WIN_SHORT: hi = d / 4 - 1;
         WIN_01: begin
            lo = d / 4;
            hi = d + d / 4 - 1;
         end
         WIN_001: begin
            lo = d + d / 4;
            hi = 2 * d - d / 4 - 1;
         end
         WIN_0001: begin
            lo = 2 * d - d / 4;
            hi = 3 * d - 1;
         end
         WIN_LONG: lo = 3 * d;
         default: ;
      endcase
      if (hi > FLUX_MAX) begin
         hi = FLUX_MAX;
      end
      if (lo > hi) begin
         lo = 0;
         hi = FLUX_MAX;
      end
      return 16'($urandom_range(hi, lo));
   endfunction

   // Intervals before any run has been seeded give nothing.
   task automatic test_before_run();
      send_interval(16'd0, 1'b0);
      send_interval(16'hFFFF, 1'b0);
   endtask

   // A run seeded with zero keeps a zero delay and treats everything as too long.
   task automatic test_zero_delay();
      send_interval(16'd0, 1'b1);
      send_interval(16'd0, 1'b0);
      send_interval(16'd1234, 1'b0);
      send_interval(16'hFFFF, 1'b0);
   endtask

   // Each window, plus too short and too long intervals, around a delay of 1000.
   task automatic test_windows();
      send_interval(16'd1000, 1'b1);
      send_interval(16'd1000, 1'b0);
      send_interval(16'd1500, 1'b0);
      send_interval(16'd2500, 1'b0);
      send_interval(16'd200, 1'b0);
      send_interval(16'd4000, 1'b0);
      send_interval(16'd250, 1'b0);
   endtask

   // Largest and smallest delays.
   task automatic test_extremes();
      send_interval(16'hFFFF, 1'b1);
      send_interval(16'hFFFF, 1'b0);
      send_interval(16'd0, 1'b0);
      send_interval(16'd1, 1'b1);
      send_interval(16'd1, 1'b0);
      send_interval(16'd3, 1'b0);
   endtask

   // Random runs, mostly intervals aimed at the three windows.
   task automatic test_random_stream(input int count, input int tx_idle, input int rx_idle);
      int          i, r;
      window_type  win;
      logic [15:0] interval;
      sender_idle_pct = tx_idle;
      rsp_idle_pct    = rx_idle;
      for (i = 0; i < count; i++) begin
         if (!run_seeded || $urandom_range(19) == 0) begin
            r = $urandom_range(9);
            if (r == 0) begin
               interval = 16'($urandom_range(3));
            end else if (r == 1) begin
               interval = 16'($urandom);
            end else begin
               interval = 16'($urandom_range(3000, 40));
            end
            send_interval(interval, 1'b1);
         end else begin
            r = $urandom_range(99);
            if (r < 10) begin
               win = WIN_ANY;
            end else if (r < 18) begin
               win = WIN_SHORT;
            end else if (r < 25) begin
               win = WIN_LONG;
            end else if (r < 55) begin
               win = WIN_01;
            end else if (r < 80) begin
               win = WIN_001;
            end else begin
               win = WIN_0001;
            end
            send_interval(pick_interval(win), 1'b0);
         end
         if (i == count / 2) begin
            drain_results();
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 37;
      rsp_idle_pct    = 85;
      test_before_run();
      test_zero_delay();
      test_windows();
      test_extremes();

      test_random_stream(70, 37, 85);
      test_random_stream(70, 85, 37);
      test_random_stream(70, 0, 0);

      drain_results();
      repeat (20) @(negedge clock);

      $display("Fed %0d intervals (directed windows, zero and extreme delays, and three",
               intervals_fed);
      $display("idling phases) and checked %0d decoded bits.", bits_checked);
      if (errors == 0 && expected_bits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d bits never received", errors, expected_bits.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
